// ===== rtl/grr_pkg.sv =====
package grr_pkg;

    // Widths of the item fields and of the configuration register.
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 5;

    // Default depth of the group buffer and reset value of the group size.
    localparam int GROUP_MAX_DEF = 16;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

endpackage

// ===== rtl/group_reverse_reorder.sv =====
// Reverses a value stream in groups of K. Each input item carries one value
// and a final flag; values are collected in a buffer of GROUP_MAX entries.
// When K values are held they leave reversed, and when a final value arrives
// before the group is full the held values leave in arrival order. On each
// emitted run, o_run_end marks the last item, and o_stream_end marks it as
// well when the run was caused by a final value. K is set through the
// configuration channel (values 0 and 1 both mean pass-through, values above
// GROUP_MAX act as GROUP_MAX) and may only be written while the block is
// idle. An input item that does not complete a run is taken with no stall.
// An item that releases a run keeps o_stall high while the run is read out,
// because the buffer has a single read port that drains one entry per cycle
// while stage A has room; output stalls lengthen this. Each result of the
// run then passes the registered buffer read (stage A) and the output
// register (stage B).
module group_reverse_reorder
    import grr_pkg::*;
#(
    parameter int GROUP_MAX = GROUP_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_is_final,
    // Output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [VALUE_W-1:0] o_out_value,
    output logic               o_run_end,
    output logic               o_stream_end,
    // Configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_group_size
);

    // Index width into the buffer and width of a count of 0..GROUP_MAX.
    localparam int CW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
    localparam int NW = $clog2(GROUP_MAX + 1);
    // Width used to compare the held count against K.
    localparam int KW = (NW > CFG_W) ? NW : CFG_W;

    // Group buffer: one write and one registered read per cycle.
    logic [VALUE_W-1:0] mem [GROUP_MAX];

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_group_size;
    logic [CW-1:0]      r_fill;     // values currently held
    logic [CW-1:0]      r_addr;     // next entry to read during a drain
    logic [NW-1:0]      r_left;     // reads still to issue
    logic               r_rev;
    logic               r_final;

    // Stage A: buffer read data; stage B: output register.
    logic               r_a_vld;
    logic [VALUE_W-1:0] r_a_data;
    logic               r_a_last;
    logic               r_a_end;
    logic               r_b_vld;
    logic [VALUE_W-1:0] r_b_data;
    logic               r_b_last;
    logic               r_b_end;

    logic               in_acc;
    logic [NW-1:0]      held_n;
    logic [KW-1:0]      k_eff;
    logic               emit_rev;
    logic               emit_any;
    logic               rd_issue;
    logic               b_free;
    logic               a_move;
    logic               rd_last;

    // Effective group size: zero behaves as one, large values saturate.
    always_comb begin
        if (r_group_size == '0) begin
            k_eff = KW'(1);
        end else if (KW'(r_group_size) > KW'(GROUP_MAX)) begin
            k_eff = KW'(GROUP_MAX);
        end else begin
            k_eff = KW'(r_group_size);
        end
    end

    // Count of held values including the one being accepted now.
    assign held_n   = NW'(r_fill) + NW'(1);
    assign emit_rev = (KW'(held_n) >= k_eff);
    assign emit_any = emit_rev || i_is_final;
    assign in_acc   = i_valid && !o_stall;

    assign b_free   = !r_b_vld || !i_stall;
    assign a_move   = r_a_vld && b_free;
    assign rd_last  = (r_left == NW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && emit_any) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (rd_issue && rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs. A read is issued only when stage A has room, so the
    // buffer output never needs a skid register.
    always_comb begin
        o_stall  = 1'b1;
        rd_issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_DRAIN: begin
                rd_issue = !r_a_vld || a_move;
            end
            default: begin
                o_stall  = 1'b1;
                rd_issue = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_group_size <= GROUP_SIZE_RST;
            r_fill       <= '0;
            r_left       <= '0;
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_group_size <= i_cfg_group_size;
            end
            if (in_acc) begin
                if (emit_any) begin
                    r_fill <= '0;
                    r_left <= held_n;
                end else begin
                    r_fill <= CW'(held_n);
                end
            end else if (rd_issue) begin
                r_left <= r_left - NW'(1);
            end
            if (rd_issue) begin
                r_a_vld <= 1'b1;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
            if (b_free) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    // Drain sequencing and payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[r_fill] <= i_value;
            r_rev       <= emit_rev;
            r_final     <= i_is_final;
            // A reversed run starts at the newest entry, a remainder at the oldest.
            r_addr      <= emit_rev ? r_fill : '0;
        end else if (rd_issue) begin
            r_addr <= r_rev ? (r_addr - CW'(1)) : (r_addr + CW'(1));
        end
        if (rd_issue) begin
            r_a_data <= mem[r_addr];
            r_a_last <= rd_last;
            r_a_end  <= rd_last && r_final;
        end
        if (b_free) begin
            r_b_data <= r_a_data;
            r_b_last <= r_a_last;
            r_b_end  <= r_a_end;
        end
    end

    assign o_valid      = r_b_vld;
    assign o_out_value  = r_b_data;
    assign o_run_end    = r_b_last;
    assign o_stream_end = r_b_end;

    // A drain always has at least one read left to issue.
    a_drain_left : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_left != '0))
        else $error("drain state with no reads left");

    // The buffer is empty whenever a run is being drained.
    a_drain_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_fill == '0))
        else $error("buffer not emptied when its run was released");

    // A final item always releases a run.
    a_final_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_is_final) |=> (r_state == ST_DRAIN))
        else $error("final item did not start a run");

    // The end of a stream is always the end of a run.
    a_end_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_end) |-> o_run_end)
        else $error("stream end without run end");

endmodule

// ===== bench/group_reverse_reorder_test.sv =====
module group_reverse_reorder_test;
    import grr_pkg::*;

    // The block is built with its default buffer depth, so the bench shares it.
    localparam int GROUP_MAX  = GROUP_MAX_DEF;
    // Generous ceiling on the run. Every value leaves the block exactly once,
    // so even with the slow phases and the long hold-off a correct run stays
    // far below this ceiling.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to let pass after the last expected result. This covers the two
    // output stages, with a margin, so that any unexpected item in flight is seen.
    localparam int SETTLE_CYCLES = 12;
    // Length of the deliberate receiver hold-off in the last phase.
    localparam int HOLD_CYCLES = 150;

    // One expected output item: a value together with its two end flags.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               run_end;
        logic               stream_end;
    } t_emitted;

    // The scoreboard keeps its own copy of the group size and of the group
    // buffer. Each accepted input item is folded in, and any run that the
    // item releases is queued value by value. Each output item is then
    // checked against the head of that queue.
    class group_reversal_book;
        logic [CFG_W-1:0]   group_size;
        logic [VALUE_W-1:0] held [GROUP_MAX];
        int unsigned        held_count;
        t_emitted           reordered_due [$];
        int unsigned        fails;

        function new();
            group_size = GROUP_SIZE_RST;
            held_count = 0;
            fails      = 0;
        endfunction

        function void set_group_size(input logic [CFG_W-1:0] k);
            group_size = k;
        endfunction

        function int unsigned pending();
            return reordered_due.size();
        endfunction

        // A group size of zero acts as one, and a size above the buffer depth
        // acts as the depth.
        function int unsigned effective_k();
            if (group_size == '0)
                return 1;
            if (group_size > GROUP_MAX)
                return GROUP_MAX;
            return 32'(group_size);
        endfunction

        function void note_value(input logic [VALUE_W-1:0] v, input logic fin);
            int unsigned k;
            int unsigned n;
            t_emitted    e;
            k = effective_k();
            if (held_count >= GROUP_MAX)
                held_count = GROUP_MAX - 1;
            held[held_count] = v;
            held_count++;
            n = held_count;
            // A run leaves the buffer when the group is full, or when the group
            // has reached or passed a lowered size. It is reversed in both cases.
            // A final item that leaves the group short sends out what is held,
            // in arrival order.
            if (n >= k || fin) begin
                for (int unsigned i = 0; i < n; i++) begin
                    e.value      = (n >= k) ? held[n - 1 - i] : held[i];
                    e.run_end    = (i == n - 1);
                    e.stream_end = fin && (i == n - 1);
                    reordered_due.push_back(e);
                end
                held_count = 0;
            end
        endfunction

        function void check_emitted(input logic [VALUE_W-1:0] v, input logic re,
                                    input logic se);
            t_emitted e;
            if (reordered_due.size() == 0) begin
                $error("output item %h with no expected item waiting", v);
                fails++;
                return;
            end
            e = reordered_due.pop_front();
            if (v !== e.value) begin
                $error("out_value: expected %h, actual %h", e.value, v);
                fails++;
            end
            if (re !== e.run_end) begin
                $error("run_end: expected %b, actual %b", e.run_end, re);
                fails++;
            end
            if (se !== e.stream_end) begin
                $error("stream_end: expected %b, actual %b", e.stream_end, se);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic               o_stall;
    logic [VALUE_W-1:0] i_value          = '0;
    logic               i_is_final       = 1'b0;
    logic               o_valid;
    logic               i_stall          = 1'b0;
    logic [VALUE_W-1:0] o_out_value;
    logic               o_run_end;
    logic               o_stream_end;
    logic               i_cfg_valid      = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_group_size = '0;

    group_reversal_book book;

    // Idle rates of the two sides, in cycles out of a hundred.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    // The stimulus raises the hold request once. The receiver process then
    // counts the hold-off in its own cycles.
    logic        hold_req      = 1'b0;
    logic        hold_done     = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    group_reverse_reorder uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_value          (i_value),
        .i_is_final       (i_is_final),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_value      (o_out_value),
        .o_run_end        (o_run_end),
        .o_stream_end     (o_stream_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_group_size (i_cfg_group_size)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // The receiver stalls at random, except during the one long hold-off.
    // During that hold-off it stalls without a break, so that the block
    // fills up and pushes back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Output items are sampled at the edge that accepts them. At that point
    // every signal still holds the value that it had before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            book.check_emitted(o_out_value, o_run_end, o_stream_end);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one item, after a random gap, and returns at the edge that takes
    // it. Valid stays high when the next item follows with no gap.
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_value    <= v;
        i_is_final <= fin;
        do @(posedge i_clk); while (o_stall);
        book.note_value(v, fin);
    endtask

    // Lowers valid and waits until every expected output item has arrived.
    // It then waits out the pipeline, so that any output item beyond those
    // expected is still seen and flagged.
    task automatic wait_until_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_group_size(input logic [CFG_W-1:0] k);
        wait_until_quiet();
        i_cfg_valid      <= 1'b1;
        i_cfg_group_size <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        book.set_group_size(k);
    endtask

    initial begin
        logic [CFG_W-1:0] size_plan [6];
        int unsigned      stream_left;
        logic             fin;

        book = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The group size is still at its reset value of two.
        // The extreme values are reversed as a pair. A lone final value is a
        // stream shorter than the group, so it leaves as a remainder. A pair
        // whose second value is final fills the group on the final item and
        // is reversed.
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h1234, 1'b1);
        send_item(16'hA5A5, 1'b0);
        send_item(16'h5A5A, 1'b1);

        // A group size of zero acts as one, so values pass straight through.
        write_group_size(5'd0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b1);

        // A size above the buffer depth saturates. Sixteen values fill the
        // largest group, and the group ends on a final item.
        write_group_size(5'd31);
        for (int i = 0; i < 16; i++)
            send_item(VALUE_W'(16'h0F00 + i), (i == 15));

        // Three values are left held. The size is then lowered below the
        // count, and the next item sends out all four as one reversed run.
        for (int i = 0; i < 3; i++)
            send_item(VALUE_W'(16'h7000 + i), 1'b0);
        write_group_size(5'd1);
        send_item(16'h8000, 1'b0);

        // Random part, in three phases of two group sizes each. Most items
        // form streams of random length that end on a final value. Now and
        // then a final value comes early and breaks a stream.
        size_plan[0] = 5'd3;
        size_plan[1] = 5'd16;
        size_plan[2] = 5'd1;
        size_plan[3] = 5'd31;
        size_plan[4] = CFG_W'($urandom_range(0, 31));
        size_plan[5] = CFG_W'($urandom_range(2, 8));
        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 2; seg++) begin
                write_group_size(size_plan[phase * 2 + seg]);
                case (phase)
                    0: begin
                        send_idle_pct = 17;
                        recv_idle_pct = 78;
                    end
                    1: begin
                        send_idle_pct = 78;
                        recv_idle_pct = 17;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                // In the last phase the receiver holds off once for a long
                // stretch, while the sender keeps offering items.
                if (phase == 2 && seg == 0)
                    hold_req <= 1'b1;
                stream_left = 0;
                for (int n = 0; n < 39; n++) begin
                    if (stream_left == 0)
                        stream_left = ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(1, 3) : $urandom_range(1, 40);
                    fin = (stream_left == 1) || ($urandom_range(0, 19) == 0);
                    stream_left = fin ? 0 : stream_left - 1;
                    send_item(VALUE_W'($urandom_range(0, 16'hFFFF)), fin);
                end
            end
        end

        wait_until_quiet();
        if (book.fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
